// ===== sv/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and codes for the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_DELETE = 3'd1;
	localparam logic [2:0] CMD_LOOKUP = 3'd2;
	localparam logic [2:0] CMD_SCAN   = 3'd3;
	localparam logic [2:0] CMD_READ   = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_DUP       = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_BAD_INDEX = 3'd4;
	localparam logic [2:0] ST_NONE      = 3'd5;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [30:0] item_key;
		logic [15:0] item_quantity;
		logic [31:0] item_price;
		logic [4:0]  entry_index;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  found_index;
		logic [30:0] found_key;
		logic [15:0] found_quantity;
		logic [31:0] found_price;
		logic [5:0]  records_held;
		logic        last_result;
	} result_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SEARCH,
		BK_SHIFT,
		BK_SCAN,
		BK_READ,
		BK_WRITE
	} bk_state_t;

endpackage

// ===== sv/krt_front.sv =====
// ----------------------------------------------------------------------------
// krt_front
// Accepts commands, drops unknown codes and queues the rest two deep.
// ----------------------------------------------------------------------------
module krt_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  krt_pkg::cmd_t  cmd_in,
	output logic           busy,
	output logic           q_valid,
	output krt_pkg::cmd_t  q_head,
	input  logic           q_pop
);
	krt_pkg::cmd_t slot_q [2];
	logic [1:0] fill_q;
	logic       rd_q;
	logic       push;
	logic       known;

	assign known = (cmd_in.cmd <= krt_pkg::CMD_READ);
	assign busy = (fill_q == 2'd2);
	assign push = start && !busy && known;
	assign q_valid = (fill_q != 2'd0);
	assign q_head = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
			rd_q <= 1'b0;
		end else begin
			if (q_pop) rd_q <= ~rd_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[rd_q ^ fill_q[0]] <= cmd_in;
	end

	// Popping from an empty queue would replay a stale command.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 2'd2) else $error("queue overfilled");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> fill_q != 2'd0) else $error("queue lost entries");
endmodule

// ===== sv/krt_back.sv =====
// ----------------------------------------------------------------------------
// krt_back
// Executes queued commands against the record memories, one entry a cycle.
// ----------------------------------------------------------------------------
module krt_back #(
	parameter int CAPACITY = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  krt_pkg::cmd_t    q_head,
	output logic             q_pop,
	input  logic [15:0]      threshold,
	output logic             strobe,
	output krt_pkg::result_t result
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [30:0] key_mem [CAPACITY];
	logic [15:0] qty_mem [CAPACITY];
	logic [31:0] price_mem [CAPACITY];

	krt_pkg::bk_state_t state_q, state_d;
	krt_pkg::cmd_t      op_q;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [AW-1:0] rd_addr;
	logic          rd_pend_q, rd_pend_d;
	logic [AW-1:0] rd_idx_q;
	logic [30:0]   rk_q;
	logic [15:0]   rq_q;
	logic [31:0]   rp_q;
	// Set once the scan has issued the read of the last stored entry.
	logic          rd_done_q, rd_done_d;
	logic          we;
	logic [AW-1:0] wa;
	logic [30:0]   wk;
	logic [15:0]   wq;
	logic [31:0]   wp;
	logic          take;
	// Pending scan hit, held back until the next hit or the end decides last.
	logic          held_q, held_d;
	krt_pkg::result_t held_r_q, held_r_d;
	logic          o_v;
	krt_pkg::result_t o_r;
	logic          rd_last;

	function automatic logic [5:0] to6(input logic [CW-1:0] v);
		return 6'(v);
	endfunction

	always_ff @(posedge clk) begin
		rk_q <= key_mem[rd_addr];
		rq_q <= qty_mem[rd_addr];
		rp_q <= price_mem[rd_addr];
		if (we) begin
			key_mem[wa] <= wk;
			qty_mem[wa] <= wq;
			price_mem[wa] <= wp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= krt_pkg::BK_IDLE;
			count_q <= '0;
			ptr_q <= '0;
			rd_pend_q <= 1'b0;
			rd_done_q <= 1'b0;
			held_q <= 1'b0;
			strobe <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ptr_q <= ptr_d;
			rd_pend_q <= rd_pend_d;
			rd_done_q <= rd_done_d;
			held_q <= held_d;
			strobe <= o_v;
		end
	end

	always_ff @(posedge clk) begin
		if (take) op_q <= q_head;
		rd_idx_q <= ptr_q;
		held_r_q <= held_r_d;
		result <= o_r;
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		ptr_d = ptr_q;
		rd_pend_d = 1'b0;
		rd_done_d = rd_done_q;
		held_d = held_q;
		held_r_d = held_r_q;
		rd_addr = ptr_q;
		take = 1'b0;
		q_pop = 1'b0;
		we = 1'b0;
		wa = ptr_q;
		wk = rk_q;
		wq = rq_q;
		wp = rp_q;
		o_v = 1'b0;
		o_r = '0;
		o_r.records_held = to6(count_q);
		o_r.last_result = 1'b1;
		rd_last = (CW'(ptr_q) + CW'(1) == count_q);
		case (state_q)
			krt_pkg::BK_IDLE: begin
				if (q_valid) begin
					take = 1'b1;
					q_pop = 1'b1;
					ptr_d = '0;
					rd_done_d = 1'b0;
					case (q_head.cmd)
						krt_pkg::CMD_READ: begin
							ptr_d = AW'(q_head.entry_index);
							state_d = krt_pkg::BK_READ;
						end
						krt_pkg::CMD_SCAN: state_d = krt_pkg::BK_SCAN;
						default: state_d = krt_pkg::BK_SEARCH;
					endcase
				end
			end
			krt_pkg::BK_READ: begin
				// Read data for ptr_q arrives in the cycle after the address.
				if (!rd_pend_q && CW'(op_q.entry_index) < count_q
				    && 32'(op_q.entry_index) < CAPACITY) begin
					rd_pend_d = 1'b1;
				end else begin
					o_v = 1'b1;
					state_d = krt_pkg::BK_IDLE;
					if (rd_pend_q) begin
						o_r.status = krt_pkg::ST_OK;
						o_r.found_index = 5'(rd_idx_q);
						o_r.found_key = rk_q;
						o_r.found_quantity = rq_q;
						o_r.found_price = rp_q;
					end else o_r.status = krt_pkg::ST_BAD_INDEX;
				end
			end
			krt_pkg::BK_SEARCH: begin
				if (op_q.cmd == krt_pkg::CMD_INSERT && count_q == CW'(CAPACITY)) begin
					o_v = 1'b1;
					o_r.status = krt_pkg::ST_FULL;
					state_d = krt_pkg::BK_IDLE;
				end else if (rd_pend_q && rk_q == op_q.item_key) begin
					o_v = 1'b1;
					state_d = krt_pkg::BK_IDLE;
					if (op_q.cmd == krt_pkg::CMD_INSERT) begin
						o_r.status = krt_pkg::ST_DUP;
					end else begin
						o_r.status = krt_pkg::ST_OK;
						o_r.found_index = 5'(rd_idx_q);
						o_r.found_key = rk_q;
						o_r.found_quantity = rq_q;
						o_r.found_price = rp_q;
						if (op_q.cmd == krt_pkg::CMD_DELETE) begin
							count_d = count_q - CW'(1);
							o_r.records_held = to6(count_d);
							ptr_d = rd_idx_q + AW'(1);
							state_d = krt_pkg::BK_SHIFT;
						end
					end
				end else if (CW'(ptr_q) < count_q) begin
					rd_pend_d = 1'b1;
					if (!rd_last) ptr_d = ptr_q + AW'(1);
					else if (rd_pend_q && rd_idx_q == ptr_q) rd_pend_d = 1'b0;
					if (rd_last && rd_pend_q && rd_idx_q == ptr_q)
						state_d = krt_pkg::BK_WRITE;
				end else begin
					state_d = krt_pkg::BK_WRITE;
				end
			end
			krt_pkg::BK_WRITE: begin
				// Search missed: insert appends, others report not found.
				o_v = 1'b1;
				state_d = krt_pkg::BK_IDLE;
				if (op_q.cmd == krt_pkg::CMD_INSERT) begin
					we = 1'b1;
					wa = AW'(count_q);
					wk = op_q.item_key;
					wq = op_q.item_quantity;
					wp = op_q.item_price;
					count_d = count_q + CW'(1);
					o_r.status = krt_pkg::ST_OK;
					o_r.found_index = 5'(count_q);
					o_r.found_key = op_q.item_key;
					o_r.found_quantity = op_q.item_quantity;
					o_r.found_price = op_q.item_price;
					o_r.records_held = to6(count_d);
				end else o_r.status = krt_pkg::ST_NOT_FOUND;
			end
			krt_pkg::BK_SHIFT: begin
				// ptr_q walks the source entries; each lands one place lower.
				if (rd_pend_q) begin
					we = 1'b1;
					wa = rd_idx_q - AW'(1);
				end
				if (CW'(ptr_q) <= count_q && !(rd_pend_q && CW'(rd_idx_q) == count_q)
				    && CW'(ptr_q) != CW'(0)) begin
					rd_pend_d = 1'b1;
					if (CW'(ptr_q) != count_q) ptr_d = ptr_q + AW'(1);
					else if (rd_pend_q && rd_idx_q == ptr_q) rd_pend_d = 1'b0;
				end
				if (!rd_pend_d) state_d = krt_pkg::BK_IDLE;
			end
			krt_pkg::BK_SCAN: begin
				if (rd_pend_q && rq_q <= threshold) begin
					if (held_q) begin
						o_v = 1'b1;
						o_r = held_r_q;
						o_r.last_result = 1'b0;
					end
					held_d = 1'b1;
					held_r_d = '0;
					held_r_d.status = krt_pkg::ST_OK;
					held_r_d.found_index = 5'(rd_idx_q);
					held_r_d.found_key = rk_q;
					held_r_d.found_quantity = rq_q;
					held_r_d.found_price = rp_q;
					held_r_d.records_held = to6(count_q);
					held_r_d.last_result = 1'b1;
				end
				if (!rd_done_q && CW'(ptr_q) < count_q) begin
					rd_pend_d = 1'b1;
					if (rd_last) rd_done_d = 1'b1;
					else ptr_d = ptr_q + AW'(1);
				end else if (!rd_pend_q) begin
					// Every entry has been read and checked, so the held hit is the last.
					state_d = krt_pkg::BK_IDLE;
					held_d = 1'b0;
					o_v = 1'b1;
					if (held_q) o_r = held_r_q;
					else o_r.status = krt_pkg::ST_NONE;
				end
			end
			default: state_d = krt_pkg::BK_IDLE;
		endcase
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY)) else $error("record count over capacity");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> state_q == krt_pkg::BK_IDLE) else $error("command taken while busy");
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> state_q != krt_pkg::BK_IDLE) else $error("write while idle");
endmodule

// ===== sv/keyed_record_table_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_record_table_unit
// Dense keyed record table with insert, delete, lookup, read and scan.
// ----------------------------------------------------------------------------
// A command beat is taken on a rising edge with start high and busy low.
// Unknown command codes are dropped. Accepted commands wait in a two-entry
// queue so a new beat can be taken while the back end is still working.
// Each result beat appears for exactly one cycle with strobe high; the
// receiver cannot stall, so results are never held back.
// Lookup and delete step through stored records one per cycle in the record
// memory's single read port. Delete then shifts the later records down, one
// per cycle. Insert runs the same duplicate search. Scan reads every record
// once, one beat per match, with last_result set on the final one, or a
// single ST_NONE beat if nothing matches.
// The threshold register is written through cfg_valid/cfg_ready; ready is
// always high, and writes are expected only while the block is idle.
// Reset clears the record count, the queue and the threshold; record
// memories are not cleared, as only entries below the count are read.
// ----------------------------------------------------------------------------
module keyed_record_table_unit #(
	parameter int CAPACITY = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  krt_pkg::cmd_t    command,
	output logic             strobe,
	output krt_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [15:0]      cfg_data
);
	logic          q_valid;
	logic          q_pop;
	krt_pkg::cmd_t q_head;
	logic [15:0]   threshold_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) threshold_q <= '0;
		else if (cfg_valid && cfg_ready) threshold_q <= cfg_data;
	end

	krt_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd_in(command), .busy(busy),
		.q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
	);

	krt_back #(.CAPACITY(CAPACITY)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_head(q_head),
		.q_pop(q_pop), .threshold(threshold_q), .strobe(strobe), .result(result)
	);
endmodule

// ===== tb/sv/tb_keyed_record_table_unit.sv =====
// ----------------------------------------------------------------------------
// tb_keyed_record_table_unit
// Self-checking bench for the keyed record table: random and directed
// commands, a behavioral table model in a scoreboard, threshold changes.
// ----------------------------------------------------------------------------
module tb_keyed_record_table_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH     = 32;
	localparam int MAX_CYC   = 2000000;
	localparam int SETTLE    = 4 * DEPTH + 40;

	// The scoreboard keeps its own copy of the table and the queue of result
	// beats that the accepted commands must produce.
	class table_scoreboard;
		logic [30:0] keys [DEPTH];
		logic [15:0] qtys [DEPTH];
		logic [31:0] prices [DEPTH];
		int          held;
		logic [15:0] threshold;
		krt_pkg::result_t pending [$];
		int          errors;

		function void clear();
			held = 0;
			threshold = '0;
			pending.delete();
			errors = 0;
		endfunction

		function int find(logic [30:0] k);
			for (int i = 0; i < held; i++)
				if (keys[i] == k) return i;
			return -1;
		endfunction

		function void push(logic [2:0] st, int pos, bit has_rec, bit last);
			krt_pkg::result_t r;
			r = '0;
			r.status = st;
			if (has_rec) begin
				r.found_index = pos[4:0];
				r.found_key = keys[pos];
				r.found_quantity = qtys[pos];
				r.found_price = prices[pos];
			end
			r.records_held = held[5:0];
			r.last_result = last;
			pending.push_back(r);
		endfunction

		function void note_command(krt_pkg::cmd_t c);
			int p;
			int n;
			case (c.cmd)
				krt_pkg::CMD_INSERT: begin
					if (held >= DEPTH) push(krt_pkg::ST_FULL, 0, 0, 1);
					else if (find(c.item_key) >= 0) push(krt_pkg::ST_DUP, 0, 0, 1);
					else begin
						keys[held] = c.item_key;
						qtys[held] = c.item_quantity;
						prices[held] = c.item_price;
						held++;
						push(krt_pkg::ST_OK, held - 1, 1, 1);
					end
				end
				krt_pkg::CMD_DELETE: begin
					p = find(c.item_key);
					if (p < 0) push(krt_pkg::ST_NOT_FOUND, 0, 0, 1);
					else begin
						held--;
						push(krt_pkg::ST_OK, p, 1, 1);
						for (int i = p; i < held; i++) begin
							keys[i] = keys[i+1];
							qtys[i] = qtys[i+1];
							prices[i] = prices[i+1];
						end
					end
				end
				krt_pkg::CMD_LOOKUP: begin
					p = find(c.item_key);
					if (p < 0) push(krt_pkg::ST_NOT_FOUND, 0, 0, 1);
					else push(krt_pkg::ST_OK, p, 1, 1);
				end
				krt_pkg::CMD_SCAN: begin
					n = 0;
					for (int i = 0; i < held; i++)
						if (qtys[i] <= threshold) begin
							if (n > 0) pending[$].last_result = 1'b0;
							push(krt_pkg::ST_OK, i, 1, 1);
							n++;
						end
					if (n == 0) push(krt_pkg::ST_NONE, 0, 0, 1);
				end
				krt_pkg::CMD_READ: begin
					if (c.entry_index >= held) push(krt_pkg::ST_BAD_INDEX, 0, 0, 1);
					else push(krt_pkg::ST_OK, c.entry_index, 1, 1);
				end
				default: ;
			endcase
		endfunction

		function void check_result(krt_pkg::result_t got);
			krt_pkg::result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result beat: %p", got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status) begin
				$error("status exp %0d got %0d", e.status, got.status); errors++;
			end
			if (got.found_index !== e.found_index) begin
				$error("found_index exp %0d got %0d", e.found_index, got.found_index);
				errors++;
			end
			if (got.found_key !== e.found_key) begin
				$error("found_key exp %0h got %0h", e.found_key, got.found_key); errors++;
			end
			if (got.found_quantity !== e.found_quantity) begin
				$error("found_quantity exp %0h got %0h", e.found_quantity,
					got.found_quantity);
				errors++;
			end
			if (got.found_price !== e.found_price) begin
				$error("found_price exp %0h got %0h", e.found_price, got.found_price);
				errors++;
			end
			if (got.records_held !== e.records_held) begin
				$error("records_held exp %0d got %0d", e.records_held, got.records_held);
				errors++;
			end
			if (got.last_result !== e.last_result) begin
				$error("last_result exp %0d got %0d", e.last_result, got.last_result);
				errors++;
			end
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	krt_pkg::cmd_t    command;
	logic    strobe;
	krt_pkg::result_t result;
	logic    cfg_valid;
	logic    cfg_ready;
	logic [15:0] cfg_data;

	table_scoreboard sb;
	int  cycles;
	bit  no_gaps;
	// Keys come from a small pool most of the time so that duplicates, hits
	// on delete and lookup, and a full table all happen often.
	logic [30:0] key_pool [16];

	keyed_record_table_unit #(.CAPACITY(DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .strobe(strobe), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Results cannot be stalled, so every strobe cycle is checked at the edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && strobe === 1'b1) sb.check_result(result);
	end

	always @(posedge clk) begin
		if (cycles >= MAX_CYC) begin
			$display("tb_keyed_record_table_unit NOT OK");
			$finish;
		end
	end

	// start stays high after an accepted beat; it drops only for an idle
	// burst or when the stream pauses in drain.
	task automatic send_command(krt_pkg::cmd_t c);
		int gap;
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= c;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_command(c);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_threshold(logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.threshold = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic krt_pkg::cmd_t make_cmd(logic [2:0] op, logic [30:0] k,
		logic [15:0] q, logic [31:0] p, logic [4:0] ix);
		krt_pkg::cmd_t c;
		c.cmd = op;
		c.item_key = k;
		c.item_quantity = q;
		c.item_price = p;
		c.entry_index = ix;
		return c;
	endfunction

	// Mostly well-formed traffic on pooled keys, with some fully random
	// keys, reads near the fill level, and the odd unknown code.
	function automatic krt_pkg::cmd_t random_cmd();
		logic [2:0]  op;
		logic [30:0] k;
		logic [15:0] q;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 35) op = krt_pkg::CMD_INSERT;
		else if (sel < 55) op = krt_pkg::CMD_DELETE;
		else if (sel < 70) op = krt_pkg::CMD_LOOKUP;
		else if (sel < 80) op = krt_pkg::CMD_SCAN;
		else if (sel < 96) op = krt_pkg::CMD_READ;
		else op = krt_pkg::CMD_READ + 3'($urandom_range(1, 3));
		k = ($urandom_range(0, 4) == 0) ? 31'($urandom) : key_pool[$urandom_range(0, 15)];
		q = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 300)) : 16'($urandom);
		return make_cmd(op, k, q, $urandom, 5'($urandom_range(0, sb.held + 1)));
	endfunction

	initial begin
		logic [15:0] thr_list [5];
		sb = new();
		sb.clear();
		cycles = 0;
		no_gaps = 0;
		arst_n = 1'b0;
		start = 1'b0;
		command = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		for (int i = 0; i < 16; i++) key_pool[i] = 31'($urandom);
		key_pool[0] = '0;
		key_pool[1] = 31'h7FFF_FFFF;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-table cases, extremes, duplicates, scans, deletes.
		send_command(make_cmd(krt_pkg::CMD_SCAN, '0, '0, '0, '0));
		send_command(make_cmd(krt_pkg::CMD_READ, '0, '0, '0, '0));
		send_command(make_cmd(krt_pkg::CMD_LOOKUP, 31'h7FFF_FFFF, '0, '0, '0));
		send_command(make_cmd(krt_pkg::CMD_DELETE, '0, '0, '0, '0));
		send_command(make_cmd(krt_pkg::CMD_INSERT, '0, '0, '0, 5'd31));
		send_command(make_cmd(krt_pkg::CMD_INSERT, 31'h7FFF_FFFF, 16'hFFFF,
			32'hFFFF_FFFF, '0));
		send_command(make_cmd(krt_pkg::CMD_INSERT, '0, 16'd5, 32'h1234_5678, '0));
		send_command(make_cmd(krt_pkg::CMD_INSERT, 31'h5555_5555, 16'h5555,
			32'hAAAA_AAAA, '0));
		// Unknown codes just past the last defined command and at the top.
		send_command(make_cmd(krt_pkg::CMD_READ + 3'd1, 31'h1, 16'd1, 32'd1, 5'd1));
		send_command(make_cmd(krt_pkg::CMD_READ + 3'd3, 31'h7FFF_FFFF, 16'hFFFF,
			32'hFFFF_FFFF, 5'd31));
		send_command(make_cmd(krt_pkg::CMD_SCAN, '0, '0, '0, '0));
		send_command(make_cmd(krt_pkg::CMD_READ, '0, '0, '0, 5'd2));
		send_command(make_cmd(krt_pkg::CMD_READ, '0, '0, '0, 5'd3));
		send_command(make_cmd(krt_pkg::CMD_READ, '0, '0, '0, 5'd31));
		send_command(make_cmd(krt_pkg::CMD_LOOKUP, 31'h5555_5555, '0, '0, '0));
		send_command(make_cmd(krt_pkg::CMD_DELETE, '0, '0, '0, '0));
		send_command(make_cmd(krt_pkg::CMD_READ, '0, '0, '0, 5'd0));
		drain();
		write_threshold(16'hFFFF);
		send_command(make_cmd(krt_pkg::CMD_SCAN, '0, '0, '0, '0));
		// Fill the table to capacity; the last two inserts of the loop and one more run past it.
		for (int i = 0; i < DEPTH; i++)
			send_command(make_cmd(krt_pkg::CMD_INSERT, 31'(32'h1000 + i), 16'(i * 7),
				$urandom, '0));
		send_command(make_cmd(krt_pkg::CMD_INSERT, 31'h2AAA_AAAA, '0, '0, '0));
		send_command(make_cmd(krt_pkg::CMD_READ, '0, '0, '0, 5'd31));
		send_command(make_cmd(krt_pkg::CMD_SCAN, '0, '0, '0, '0));
		send_command(make_cmd(krt_pkg::CMD_DELETE, 31'h1000, '0, '0, '0));
		drain();

		// Random phases under several thresholds, extremes included.
		thr_list[0] = 16'd0;
		thr_list[1] = 16'd150;
		thr_list[2] = 16'hFFFF;
		thr_list[3] = 16'($urandom);
		thr_list[4] = 16'd300;
		for (int ph = 0; ph < 5; ph++) begin
			write_threshold(thr_list[ph]);
			if (ph == 4) no_gaps = 1;
			for (int i = 0; i < 40; i++) send_command(random_cmd());
			drain();
		end

		if (sb.errors == 0) $display("tb_keyed_record_table_unit OK");
		else $display("tb_keyed_record_table_unit NOT OK");
		$finish;
	end
endmodule

// ===== files.f =====
sv/krt_pkg.sv
sv/krt_front.sv
sv/krt_back.sv
sv/keyed_record_table_unit.sv
tb/sv/tb_keyed_record_table_unit.sv
